@@ hw/rtl/bba_pkg.sv @@
package bba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = MAX_BLOCKS / WORD_W;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WIDX_W     = $clog2(NUM_WORDS);
    localparam int BLK_W      = 10;
    localparam int CNT_W      = 11;
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;

    localparam int RESET_BLOCKS   = 1024;
    localparam int RESET_RESERVED = 10;
    localparam int RESET_MANAGED  = (RESET_BLOCKS < MAX_BLOCKS) ? RESET_BLOCKS : MAX_BLOCKS;
    localparam int RESET_LIM_I    =
        (RESET_RESERVED < RESET_MANAGED) ? RESET_RESERVED : RESET_MANAGED;
    localparam logic [CNT_W-1:0] RESET_LIM  = CNT_W'(RESET_LIM_I);
    localparam logic [CNT_W-1:0] RESET_FREE = CNT_W'(RESET_MANAGED - RESET_LIM_I);
    localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_BLOCKS);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_QUERY  = 3'd2,
        OP_MARK   = 3'd3,
        OP_FORMAT = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_OUT
    } t_state;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;

    typedef logic [WORD_W-1:0] t_word;

    function automatic logic [CNT_W-1:0] word_base(input logic [WIDX_W-1:0] w);
        return CNT_W'({w, {BIT_W{1'b0}}});
    endfunction

    function automatic t_word fmt_row(input logic [WIDX_W-1:0] w,
                                      input logic [CNT_W-1:0]  lim);
        logic [CNT_W-1:0] base;
        base = word_base(w);
        if (lim >= base + CNT_W'(WORD_W)) begin
            return '1;
        end else if (lim <= base) begin
            return '0;
        end else begin
            return (t_word'(1) << lim[BIT_W-1:0]) - t_word'(1);
        end
    endfunction

    function automatic logic [NUM_WORDS-1:0] fmt_full(input logic [CNT_W-1:0] lim);
        logic [NUM_WORDS-1:0] full;
        for (int w = 0; w < NUM_WORDS; w++) begin
            full[w] = (lim >= word_base(WIDX_W'(w)) + CNT_W'(WORD_W));
        end
        return full;
    endfunction

endpackage

@@ hw/rtl/bitmap_block_allocator_top.sv @@
// First-fit bitmap block allocator.
// Input channel: i_in_valid / o_in_stall carry one request (i_op, i_block_index).
// Output channel: o_out_valid / i_out_stall carry one result per request
// (o_status, o_granted_block, o_block_was_used, o_free_count).
// An item is taken at a clock edge with valid high and stall low.
// Each accepted request passes through states S_ADDR and S_DATA and then raises
// o_out_valid in S_OUT; one item is worked on at a time, so no new request is
// taken until the result has left. The map RAM sets the steps: S_ADDR picks the
// word (for an alloc, summary lookup through the shared first-free finder) and
// issues the registered read, S_DATA updates the word, writes it back and
// registers the result.
// While the receiver stalls, the result holds and o_in_stall stays high.
// Format takes the same path: rows are marked stale and read back as
// the reserved pattern until written again.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 block count, 1 reserved count); write only while no item is in flight.
// Reset (i_rst_n low, synchronous) sets block count 1024, reserved 10, and a
// map with the first ten blocks used, with no clearing pass.
module bitmap_block_allocator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bba_pkg::OP_W-1:0]       i_op,
    input  logic [bba_pkg::BLK_W-1:0]      i_block_index,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bba_pkg::ST_W-1:0]       o_status,
    output logic [bba_pkg::BLK_W-1:0]      o_granted_block,
    output logic                           o_block_was_used,
    output logic [bba_pkg::CNT_W-1:0]      o_free_count,
    input  logic                           i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bba_pkg::CNT_W-1:0]      i_cfg_data
);

    bba_pkg::t_state r_state, n_state;
    bba_pkg::t_op    r_op;
    logic [bba_pkg::BLK_W-1:0]     r_idx;
    logic [bba_pkg::WIDX_W-1:0]    r_word;
    logic                          r_none;
    bba_pkg::t_word                r_rd_data;
    bba_pkg::t_word                r_map [bba_pkg::NUM_WORDS];
    logic [bba_pkg::NUM_WORDS-1:0] r_row_valid;
    logic [bba_pkg::NUM_WORDS-1:0] r_full;
    logic [bba_pkg::CNT_W-1:0]     r_fmt_lim;
    logic [bba_pkg::CNT_W-1:0]     r_free_total, n_free;
    logic [bba_pkg::CNT_W-1:0]     r_blocks;
    logic [bba_pkg::CNT_W-1:0]     r_reserved;
    bba_pkg::t_status              r_status, n_status;
    logic [bba_pkg::BLK_W-1:0]     r_granted, n_granted;
    logic                          r_was_used, n_was_used;

    bba_pkg::t_word                cur_word, new_word, ffs_vec;
    logic                          ffs_found;
    logic [bba_pkg::BIT_W-1:0]     ffs_idx;
    logic [bba_pkg::WIDX_W-1:0]    rd_addr;
    logic [bba_pkg::CNT_W-1:0]     managed, lim_new, cnt_dec, cnt_inc;
    logic [bba_pkg::BLK_W-1:0]     cand;
    logic [bba_pkg::BIT_W-1:0]     bit_sel;
    logic                          in_range, map_we, do_format, accept;

    assign accept = i_in_valid && !o_in_stall;

    assign managed = (r_blocks > bba_pkg::MAX_CNT) ? bba_pkg::MAX_CNT : r_blocks;
    assign lim_new = (r_reserved < managed) ? r_reserved : managed;
    assign cnt_dec = (r_free_total != '0) ? r_free_total - 1'b1 : r_free_total;
    assign cnt_inc = (r_free_total < bba_pkg::MAX_CNT) ? r_free_total + 1'b1 : r_free_total;

    assign cur_word = r_row_valid[r_word] ? r_rd_data
                                          : bba_pkg::fmt_row(r_word, r_fmt_lim);
    assign ffs_vec  = (r_state == bba_pkg::S_ADDR) ? ~r_full : ~cur_word;

    bba_ffs u_ffs (
        .i_vec   (ffs_vec),
        .o_found (ffs_found),
        .o_idx   (ffs_idx)
    );

    assign rd_addr  = (r_op == bba_pkg::OP_ALLOC) ? ffs_idx
                                                  : r_idx[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    assign cand     = {r_word, ffs_idx};
    assign bit_sel  = r_idx[bba_pkg::BIT_W-1:0];
    assign in_range = bba_pkg::CNT_W'(r_idx) < managed;

    always_comb begin
        new_word   = cur_word;
        n_status   = bba_pkg::ST_OK;
        n_granted  = '0;
        n_was_used = 1'b0;
        n_free     = r_free_total;
        map_we     = 1'b0;
        do_format  = 1'b0;
        unique case (r_op)
            bba_pkg::OP_ALLOC: begin
                map_we = 1'b1;
                if (!r_none && ffs_found && bba_pkg::CNT_W'(cand) < managed) begin
                    new_word[ffs_idx] = 1'b1;
                    n_granted         = cand;
                    n_free            = cnt_dec;
                end else begin
                    n_status = bba_pkg::ST_FULL;
                end
            end
            bba_pkg::OP_FREE, bba_pkg::OP_QUERY, bba_pkg::OP_MARK: begin
                map_we = 1'b1;
                if (!in_range) begin
                    n_status   = bba_pkg::ST_RANGE;
                    n_was_used = 1'b1;
                end else begin
                    n_was_used = cur_word[bit_sel];
                    if (r_op == bba_pkg::OP_FREE && cur_word[bit_sel]) begin
                        new_word[bit_sel] = 1'b0;
                        n_free            = cnt_inc;
                    end else if (r_op == bba_pkg::OP_MARK && !cur_word[bit_sel]) begin
                        new_word[bit_sel] = 1'b1;
                        n_free            = cnt_dec;
                    end
                end
            end
            bba_pkg::OP_FORMAT: begin
                do_format = 1'b1;
                n_free    = managed - lim_new;
            end
            default: begin
                n_status = bba_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_IDLE: if (i_in_valid) n_state = bba_pkg::S_ADDR;
            bba_pkg::S_ADDR: n_state = bba_pkg::S_DATA;
            bba_pkg::S_DATA: n_state = bba_pkg::S_OUT;
            bba_pkg::S_OUT:  if (!i_out_stall) n_state = bba_pkg::S_IDLE;
            default:         n_state = bba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bba_pkg::S_IDLE;
            r_row_valid  <= '0;
            r_full       <= bba_pkg::fmt_full(bba_pkg::RESET_LIM);
            r_fmt_lim    <= bba_pkg::RESET_LIM;
            r_free_total <= bba_pkg::RESET_FREE;
            r_blocks     <= bba_pkg::CNT_W'(bba_pkg::RESET_BLOCKS);
            r_reserved   <= bba_pkg::CNT_W'(bba_pkg::RESET_RESERVED);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bba_pkg::CFG_BLOCKS:   r_blocks   <= i_cfg_data;
                    bba_pkg::CFG_RESERVED: r_reserved <= i_cfg_data;
                    default:               r_blocks   <= r_blocks;
                endcase
            end
            if (r_state == bba_pkg::S_DATA) begin
                r_free_total <= n_free;
                if (do_format) begin
                    r_row_valid <= '0;
                    r_full      <= bba_pkg::fmt_full(lim_new);
                    r_fmt_lim   <= lim_new;
                end else if (map_we) begin
                    r_row_valid[r_word] <= 1'b1;
                    r_full[r_word]      <= &new_word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= bba_pkg::t_op'(i_op);
            r_idx <= i_block_index;
        end
        if (r_state == bba_pkg::S_ADDR) begin
            r_word    <= rd_addr;
            r_none    <= !ffs_found;
            r_rd_data <= r_map[rd_addr];
        end
        if (r_state == bba_pkg::S_DATA) begin
            if (map_we) begin
                r_map[r_word] <= new_word;
            end
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_was_used <= n_was_used;
        end
    end

    assign o_in_stall       = (r_state != bba_pkg::S_IDLE);
    assign o_out_valid      = (r_state == bba_pkg::S_OUT);
    assign o_status         = r_status;
    assign o_granted_block  = r_granted;
    assign o_block_was_used = r_was_used;
    assign o_free_count     = r_free_total;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##3 o_out_valid)
        else $error("result not ready three cycles after acceptance");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= bba_pkg::MAX_CNT)
        else $error("free count above block maximum");

    a_full_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bba_pkg::ST_FULL) |-> (o_granted_block == '0))
        else $error("grant reported with no free block");

    a_range_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bba_pkg::ST_RANGE) |-> o_block_was_used)
        else $error("out of range block not read as used");

endmodule

@@ hw/rtl/bba_ffs.sv @@
module bba_ffs (
    input  logic [bba_pkg::WORD_W-1:0] i_vec,
    output logic                       o_found,
    output logic [bba_pkg::BIT_W-1:0]  o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = bba_pkg::BIT_W'(i);
            end
        end
    end

    assign o_found = |i_vec;

endmodule

@@ verif/testbench.sv @@
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 95;
    localparam logic [bba_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [bba_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [bba_pkg::OP_W-1:0]  op;
        logic [bba_pkg::BLK_W-1:0] index;
        int                        gap;
    } t_request;

    typedef struct {
        bba_pkg::t_status          status;
        logic [bba_pkg::BLK_W-1:0] granted;
        logic                      was_used;
        logic [bba_pkg::CNT_W-1:0] free_count;
    } t_answer;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [bba_pkg::OP_W-1:0]      i_op = '0;
    logic [bba_pkg::BLK_W-1:0]     i_block_index = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [bba_pkg::ST_W-1:0]      o_status;
    logic [bba_pkg::BLK_W-1:0]     o_granted_block;
    logic                          o_block_was_used;
    logic [bba_pkg::CNT_W-1:0]     o_free_count;
    logic                          i_cfg_we = 1'b0;
    logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bba_pkg::CNT_W-1:0]     i_cfg_data = '0;

    t_request pending_requests[$];
    t_answer  expected_answers[$];

    logic block_used [bba_pkg::MAX_BLOCKS];
    int   model_free;
    int   cfg_block_count;
    int   cfg_reserved;

    int idle_cycles = 0;
    int rx_wait = 0;
    int rx_hold = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int answers_seen = 0;
    int grants_seen = 0;
    int full_seen = 0;
    int range_seen = 0;
    int formats_sent = 0;
    int mismatch_count = 0;

    bitmap_block_allocator_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_block_index    (i_block_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_granted_block  (o_granted_block),
        .o_block_was_used (o_block_was_used),
        .o_free_count     (o_free_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int managed_blocks();
        return (cfg_block_count < bba_pkg::MAX_BLOCKS) ? cfg_block_count
                                                       : bba_pkg::MAX_BLOCKS;
    endfunction

    function automatic void format_map();
        int span;
        int lim;
        span = managed_blocks();
        lim = (cfg_reserved < span) ? cfg_reserved : span;
        for (int b = 0; b < bba_pkg::MAX_BLOCKS; b++) begin
            block_used[b] = (b < lim);
        end
        model_free = span - lim;
    endfunction

    function automatic void predict_answer(input logic [bba_pkg::OP_W-1:0] op,
                                           input logic [bba_pkg::BLK_W-1:0] index);
        t_answer a;
        int      span;
        logic    found;
        span = managed_blocks();
        found = 1'b0;
        a.status = bba_pkg::ST_OK;
        a.granted = '0;
        a.was_used = 1'b0;
        case (op)
            bba_pkg::OP_ALLOC: begin
                a.status = bba_pkg::ST_FULL;
                for (int b = 0; b < span; b++) begin
                    if (!found && !block_used[b]) begin
                        found = 1'b1;
                        block_used[b] = 1'b1;
                        if (model_free > 0) model_free--;
                        a.granted = bba_pkg::BLK_W'(b);
                        a.status = bba_pkg::ST_OK;
                    end
                end
            end
            bba_pkg::OP_FREE, bba_pkg::OP_QUERY, bba_pkg::OP_MARK: begin
                if (int'(index) >= span) begin
                    a.status = bba_pkg::ST_RANGE;
                    a.was_used = 1'b1;
                end else begin
                    a.was_used = block_used[index];
                    if (op == bba_pkg::OP_FREE && a.was_used) begin
                        block_used[index] = 1'b0;
                        if (model_free < bba_pkg::MAX_BLOCKS) model_free++;
                    end else if (op == bba_pkg::OP_MARK && !a.was_used) begin
                        block_used[index] = 1'b1;
                        if (model_free > 0) model_free--;
                    end
                end
            end
            bba_pkg::OP_FORMAT: begin
                format_map();
            end
            default: begin
            end
        endcase
        a.free_count = bba_pkg::CNT_W'(model_free);
        expected_answers.push_back(a);
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Driver: present the next pending item once its gap has passed.
    always @(posedge i_clk) begin : drive_requests
        logic     next_valid;
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_cycles <= 0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_answer(i_op, i_block_index);
                requests_sent++;
                if (i_op == bba_pkg::OP_FORMAT) formats_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (pending_requests.size() != 0 && idle_cycles >= pending_requests[0].gap) begin
                    req = pending_requests.pop_front();
                    i_op <= req.op;
                    i_block_index <= req.index;
                    next_valid = 1'b1;
                    idle_cycles <= 0;
                end else begin
                    idle_cycles <= idle_cycles + 1;
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Monitor: check each answer against the oldest prediction, then draw a stall.
    always @(posedge i_clk) begin : check_answers
        t_answer want;
        logic    stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    $error("answer with nothing expected: status %0d", o_status);
                    mismatch_count++;
                end else begin
                    want = expected_answers.pop_front();
                    compare_field("status", want.status, o_status);
                    compare_field("granted_block", want.granted, o_granted_block);
                    compare_field("block_was_used", want.was_used, o_block_was_used);
                    compare_field("free_count", want.free_count, o_free_count);
                    case (want.status)
                        bba_pkg::ST_FULL:  full_seen++;
                        bba_pkg::ST_RANGE: range_seen++;
                        default:  if (want.granted != 0 || o_granted_block != 0) grants_seen++;
                    endcase
                end
                answers_seen++;
                // hold off long enough that the block backs up its input
                if (answers_seen == 250 || answers_seen == 600) rx_hold = 60;
                else if (answers_seen >= 400 && answers_seen < 480) rx_wait = 0;
                else rx_wait = $urandom_range(0, 4);
            end
            stall = 1'b0;
            if (rx_hold > 0) begin
                rx_hold--;
                stall = 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                stall = 1'b1;
            end
            i_out_stall <= stall;
        end
    end

    task automatic add_request(input logic [bba_pkg::OP_W-1:0] op, input int index,
                               input int gap);
        t_request req;
        req.op = op;
        req.index = bba_pkg::BLK_W'(index);
        req.gap = gap;
        pending_requests.push_back(req);
    endtask

    task automatic add_directed(input logic [bba_pkg::OP_W-1:0] op, input int index);
        add_request(op, index, $urandom_range(0, 4));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_answers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [bba_pkg::CFG_IDX_W-1:0] index,
                                  input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= bba_pkg::CNT_W'(value);
        if (index == bba_pkg::CFG_BLOCKS) cfg_block_count = value & 'h7FF;
        else cfg_reserved = value & 'h7FF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_registers(input int blocks, input int reserved);
        wait_idle();
        write_register(bba_pkg::CFG_BLOCKS, blocks);
        write_register(bba_pkg::CFG_RESERVED, reserved);
        @(negedge i_clk);
    endtask

    task automatic add_random_requests(input int count, input logic no_gaps);
        int span;
        int pick;
        int index;
        int top;
        logic [bba_pkg::OP_W-1:0] op;
        span = managed_blocks();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 32) op = bba_pkg::OP_ALLOC;
            else if (pick < 60) op = bba_pkg::OP_FREE;
            else if (pick < 75) op = bba_pkg::OP_QUERY;
            else if (pick < 92) op = bba_pkg::OP_MARK;
            else if (pick < 96) op = bba_pkg::OP_FORMAT;
            else op = bba_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            pick = $urandom_range(0, 9);
            if (pick < 7 && span > 0) begin
                index = $urandom_range(0, span - 1);
            end else if (pick < 9 && span < bba_pkg::MAX_BLOCKS) begin
                top = (span + 3 < bba_pkg::MAX_BLOCKS) ? span + 3 : bba_pkg::MAX_BLOCKS - 1;
                index = $urandom_range(span, top);
            end else begin
                index = $urandom_range(0, bba_pkg::MAX_BLOCKS - 1);
            end
            add_request(op, index, no_gaps ? 0 : $urandom_range(0, 4));
        end
    endtask

    initial begin
        int blocks;
        int reserved;
        cfg_block_count = bba_pkg::RESET_BLOCKS;
        cfg_reserved = bba_pkg::RESET_RESERVED;
        format_map();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset map: reserved edge, top block, redundant free and mark, spare codes
        add_directed(bba_pkg::OP_QUERY, 0);
        add_directed(bba_pkg::OP_QUERY, 9);
        add_directed(bba_pkg::OP_QUERY, bba_pkg::MAX_BLOCKS - 1);
        add_directed(bba_pkg::OP_ALLOC, 0);
        add_directed(bba_pkg::OP_FREE, 10);
        add_directed(bba_pkg::OP_FREE, 10);
        add_directed(bba_pkg::OP_MARK, bba_pkg::MAX_BLOCKS - 1);
        add_directed(bba_pkg::OP_MARK, bba_pkg::MAX_BLOCKS - 1);
        add_directed(bba_pkg::OP_FREE, 0);
        add_directed(bba_pkg::OP_ALLOC, 0);
        add_directed(OP_SPARE_LO, 682);
        add_directed(OP_SPARE_HI, 341);
        add_directed(bba_pkg::OP_FORMAT, 0);
        add_directed(bba_pkg::OP_QUERY, 0);

        // single block: fill it, then hit the full and out-of-range answers
        set_registers(1, 0);
        add_directed(bba_pkg::OP_FORMAT, 0);
        add_directed(bba_pkg::OP_ALLOC, 0);
        add_directed(bba_pkg::OP_ALLOC, 0);
        add_directed(bba_pkg::OP_QUERY, 1);
        add_directed(bba_pkg::OP_FREE, bba_pkg::MAX_BLOCKS - 1);

        // reserve beyond the count, then widen without formatting
        set_registers(8, bba_pkg::MAX_BLOCKS);
        add_directed(bba_pkg::OP_FORMAT, 0);
        add_directed(bba_pkg::OP_ALLOC, 0);
        set_registers(0, 0);
        add_directed(bba_pkg::OP_QUERY, 0);
        add_directed(bba_pkg::OP_ALLOC, 0);
        set_registers(bba_pkg::RESET_BLOCKS, bba_pkg::RESET_RESERVED);
        add_directed(bba_pkg::OP_ALLOC, 0);
        add_directed(bba_pkg::OP_ALLOC, 0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin blocks = 1024; reserved = 10; end
                1: begin blocks = 16; reserved = 3; end
                2: begin blocks = 1; reserved = 0; end
                3: begin blocks = 64; reserved = 70; end
                4: begin blocks = 8; reserved = 0; end
                5: begin blocks = 1024; reserved = 1024; end
                6: begin blocks = 0; reserved = 5; end
                7: begin blocks = 2047; reserved = 2047; end
                default: begin
                    blocks = $urandom_range(1, 1024);
                    reserved = $urandom_range(0, 64);
                end
            endcase
            set_registers(blocks, reserved);
            // leave the count stale on odd phases
            if (p % 2 == 0) add_directed(bba_pkg::OP_FORMAT, 0);
            add_random_requests(PHASE_ITEMS, p == 3);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("testbench: %0d requests, %0d answers checked, %0d formats",
                 requests_sent, answers_seen, formats_sent);
        $display("testbench: %0d nonzero grants, %0d no-free answers, %0d out-of-range answers",
                 grants_seen, full_seen, range_seen);
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_ffs.sv
hw/rtl/bitmap_block_allocator_top.sv
verif/testbench.sv
